FILE: hw/rtl/mpr_pkg.sv
`timescale 1ns / 1ps
package mpr_pkg;

  // index width covers the largest supported matrix size (16)
  localparam int IDX_W = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  // operand transaction handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [IDX_W-1:0]  k;
    logic [IDX_W-1:0]  row;
    logic signed [31:0] val;
  } op_t;

  // finished dot product of one cell
  typedef struct packed {
    logic              valid;
    logic              ovf;
    logic [IDX_W-1:0]  row;
    logic signed [31:0] value;
  } res_t;

endpackage

FILE: hw/rtl/mpr_cell.sv
`timescale 1ns / 1ps
module mpr_cell
  import mpr_pkg::*;
#(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_we,
  input  logic [IDX_W-1:0]   src_row,
  input  logic signed [31:0] src_data,
  input  op_t                op_in,
  output op_t                op_out,
  output res_t               res
);

  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ACC_W = 64 - FRAC_BITS + $clog2(MAX_DIM) + 1;

  logic signed [31:0]      src_col [MAX_DIM];
  logic signed [63:0]      prod;
  op_t                     s1;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] shifted;
  logic signed [ACC_W-1:0] sum;
  logic                    done;
  logic [IDX_W-1:0]        done_row;
  logic [ACC_W-32:0]       hi;

  // column of the source matrix held by this cell
  always_ff @(posedge clk) begin
    if (src_we) begin
      src_col[src_row[IW-1:0]] <= src_data;
    end
  end

  // pass operand to the neighbor, multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      op_out.valid <= 1'b0;
      s1.valid     <= 1'b0;
    end else begin
      op_out.valid <= op_in.valid;
      s1.valid     <= op_in.valid;
    end
    op_out.first <= op_in.first;
    op_out.last  <= op_in.last;
    op_out.k     <= op_in.k;
    op_out.row   <= op_in.row;
    op_out.val   <= op_in.val;
    s1.first     <= op_in.first;
    s1.last      <= op_in.last;
    s1.k         <= op_in.k;
    s1.row       <= op_in.row;
    s1.val       <= op_in.val;
    prod         <= op_in.val * src_col[op_in.k[IW-1:0]];
  end

  always_comb begin
    shifted = ACC_W'(prod >>> FRAC_BITS);
    sum     = (s1.first ? '0 : acc) + shifted;
  end

  // accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1.valid & s1.last;
    end
    if (s1.valid) begin
      acc <= sum;
    end
    done_row <= s1.row;
  end

  // saturate to 32 bits
  always_comb begin
    hi        = acc[ACC_W-1:31];
    res.valid = done;
    res.row   = done_row;
    res.ovf   = 1'b0;
    if ((~|hi) || (&hi)) begin
      res.value = acc[31:0];
    end else begin
      res.ovf   = 1'b1;
      res.value = acc[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

endmodule

FILE: hw/rtl/matrix_power_repeated_multiply.sv
`timescale 1ns / 1ps
// Matrix power by repeated multiplication, signed fixed point.
//
// Input channel (element_value / element_valid / element_stall): one matrix
// element per transaction, row-major. Configuration (APB, dimension at 0,
// exponent at 4) is to be written only while the block is idle; the block
// itself does not enforce this. Writing dimension restarts loading.
// After the last element the block starts from the identity and multiplies
// by the loaded matrix exponent times. A row of MAX_DIM cells, one per result
// column, each holding one column of the source, does the multiply-adds; the
// row operand travels down the chain one cell per cycle. Each step issues
// d*d row operands, then drains the chain; it runs out of a ping-pong product
// memory with one read and one write port. Output channel (result_* /
// result_valid / result_stall): d*d transactions, row-major, one at a time,
// each read from the product memory before it is offered; last_of_run marks
// the final one. element_stall stays high from the last element until the
// final result transaction completes; a stalled result simply holds.
// Reset clears the load position, registers (dimension 2, exponent 1) and
// the overflow flag; no memory clearing pass is needed.
module matrix_power_repeated_multiply
  import mpr_pkg::*;
#(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input elements
  input  logic signed [31:0] element_value,
  input  logic               element_valid,
  output logic               element_stall,
  // results
  output logic signed [31:0] result_value,
  output logic [2:0]         row_index,
  output logic [2:0]         col_index,
  output logic               overflow_seen,
  output logic               last_of_run,
  output logic               result_valid,
  input  logic               result_stall
);

  localparam int IW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW        = $clog2(MAX_DIM + 1);
  localparam int AW        = 1 + 2 * IW;
  localparam int DRAIN_LEN = MAX_DIM + 8;
  localparam int CW        = $clog2(DRAIN_LEN + 1);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  state_t state, state_next;

  logic [3:0]    dimension;
  logic [7:0]    exponent;
  logic [DW-1:0] d_eff;
  logic [IW-1:0] d_last;

  logic [IW-1:0] row_ld, col_ld;
  logic [IW-1:0] iss_i, iss_k;
  logic [IW-1:0] er, ec;
  logic [CW-1:0] drain_cnt;
  logic [7:0]    steps;
  logic          bank_r;
  logic          ident_mode;
  logic          ident_out;
  logic          ovf_flag;

  logic          cfg_wr;
  logic          in_acc;
  logic          load_last;
  logic          issue;
  logic          out_take;

  logic signed [31:0] mem [2**AW];
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic               wr_ovf;

  op_t  tag_q;
  op_t  chain [MAX_DIM+1];
  res_t cres  [MAX_DIM];

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= 4'd2;
      exponent  <= 8'd1;
    end else if (cfg_wr) begin
      if (paddr[2] == 1'b0) begin
        dimension <= pwdata[3:0];
      end else begin
        exponent <= pwdata[7:0];
      end
    end
  end

  assign prdata = paddr[2] ? {24'd0, exponent} : {28'd0, dimension};

  // clamp dimension to 1..MAX_DIM
  always_comb begin
    if (dimension == 4'd0) begin
      d_eff = DW'(1);
    end else if ({1'b0, dimension} > 5'(MAX_DIM)) begin
      d_eff = DW'(MAX_DIM);
    end else begin
      d_eff = DW'(dimension);
    end
    d_last = IW'(d_eff - DW'(1));
  end

  // ---------------- control sequencer ----------------
  assign in_acc    = element_valid & ~element_stall;
  assign load_last = (row_ld == d_last) && (col_ld == d_last);
  assign out_take  = result_valid & ~result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && load_last) begin
          state_next = (exponent == 8'd0) ? ST_EMIT_RD : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (iss_i == d_last && iss_k == d_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == CW'(DRAIN_LEN)) begin
          state_next = (steps == 8'd1) ? ST_EMIT_RD : ST_ISSUE;
        end
      end
      ST_EMIT_RD:   state_next = ST_EMIT_LD;
      ST_EMIT_LD:   state_next = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (out_take) begin
          state_next = (er == d_last && ec == d_last) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    element_stall = (state != ST_IDLE);
    issue         = (state == ST_ISSUE);
    if (state == ST_ISSUE) begin
      rd_addr = {bank_r, iss_i, iss_k};
    end else begin
      rd_addr = {bank_r, er, ec};
    end
  end

  // load position, compute and emit counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ld     <= '0;
      col_ld     <= '0;
      iss_i      <= '0;
      iss_k      <= '0;
      er         <= '0;
      ec         <= '0;
      drain_cnt  <= '0;
      steps      <= '0;
      bank_r     <= 1'b0;
      ident_mode <= 1'b0;
      ident_out  <= 1'b0;
      ovf_flag   <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == 1'b0) begin
        // new dimension: drop any partial load
        row_ld <= '0;
        col_ld <= '0;
      end else if (in_acc) begin
        if (col_ld == d_last) begin
          col_ld <= '0;
          row_ld <= load_last ? '0 : row_ld + IW'(1);
        end else begin
          col_ld <= col_ld + IW'(1);
        end
      end

      if (state == ST_IDLE && in_acc && load_last) begin
        iss_i      <= '0;
        iss_k      <= '0;
        er         <= '0;
        ec         <= '0;
        steps      <= exponent;
        ident_mode <= 1'b1;
        ident_out  <= (exponent == 8'd0);
        ovf_flag   <= 1'b0;
      end

      if (state == ST_ISSUE) begin
        drain_cnt <= '0;
        if (iss_k == d_last) begin
          iss_k <= '0;
          iss_i <= iss_i + IW'(1);
        end else begin
          iss_k <= iss_k + IW'(1);
        end
      end

      if (state == ST_DRAIN) begin
        drain_cnt <= drain_cnt + CW'(1);
        if (drain_cnt == CW'(DRAIN_LEN)) begin
          // fresh product now lives in the other bank
          bank_r     <= ~bank_r;
          ident_mode <= 1'b0;
          steps      <= steps - 8'd1;
          iss_i      <= '0;
          iss_k      <= '0;
        end
      end

      if (wr_en && wr_ovf) begin
        ovf_flag <= 1'b1;
      end

      if (state == ST_EMIT_WAIT && out_take) begin
        if (ec == d_last) begin
          ec <= '0;
          er <= er + IW'(1);
        end else begin
          ec <= ec + IW'(1);
        end
      end
    end
  end

  // ---------------- product memory (ping-pong banks) ----------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // align issue tags with the registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q.valid <= 1'b0;
    end else begin
      tag_q.valid <= issue;
    end
    tag_q.first <= (iss_k == '0);
    tag_q.last  <= (iss_k == d_last);
    tag_q.k     <= IDX_W'(iss_k);
    tag_q.row   <= IDX_W'(iss_i);
    tag_q.val   <= '0;
  end

  // head of the chain: product row element, or identity on the first step
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid <= tag_q.valid;
    end
    chain[0].first <= tag_q.first;
    chain[0].last  <= tag_q.last;
    chain[0].k     <= tag_q.k;
    chain[0].row   <= tag_q.row;
    if (ident_mode) begin
      chain[0].val <= (tag_q.row == tag_q.k) ? ONE : 32'sd0;
    end else begin
      chain[0].val <= rd_data;
    end
  end

  // ---------------- cell chain ----------------
  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    mpr_cell #(
      .MAX_DIM  (MAX_DIM),
      .FRAC_BITS(FRAC_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .src_we  (in_acc && col_ld == IW'(j)),
      .src_row (IDX_W'(row_ld)),
      .src_data(element_value),
      .op_in   (chain[j]),
      .op_out  (chain[j+1]),
      .res     (cres[j])
    );
  end

  // cells finish in skewed cycles, so at most one active column reports
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    wr_ovf  = 1'b0;
    for (int j = 0; j < MAX_DIM; j++) begin
      if (cres[j].valid && (DW'(j) < d_eff)) begin
        wr_en   = 1'b1;
        wr_addr = {~bank_r, cres[j].row[IW-1:0], IW'(j)};
        wr_data = cres[j].value;
        wr_ovf  = cres[j].ovf;
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_EMIT_LD) begin
      result_valid <= 1'b1;
    end else if (out_take) begin
      result_valid <= 1'b0;
    end
    if (state == ST_EMIT_LD) begin
      result_value  <= ident_out ? ((er == ec) ? ONE : 32'sd0) : rd_data;
      row_index     <= 3'(er);
      col_index     <= 3'(ec);
      overflow_seen <= ovf_flag;
      last_of_run   <= (er == d_last) && (ec == d_last);
    end
  end

endmodule

FILE: hw/rtl/mpr_checker.sv
`timescale 1ns / 1ps
module mpr_checker (
  input logic               clk,
  input logic               rst,
  input logic               element_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [31:0] result_value,
  input logic [2:0]         row_index,
  input logic [2:0]         col_index,
  input logic               last_of_run
);

  // a held result keeps its value and row index
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result_value) && $stable(row_index))
    else $error("stalled result changed");

  // no new element while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> element_stall)
    else $error("input taken during output");

  // the last element sits on the diagonal
  a_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_run |-> row_index == col_index)
    else $error("last mark off the diagonal");

  // reset drops the output
  a_rst: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind matrix_power_repeated_multiply mpr_checker u_mpr_checker (
  .clk          (clk),
  .rst          (rst),
  .element_stall(element_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_value (result_value),
  .row_index    (row_index),
  .col_index    (col_index),
  .last_of_run  (last_of_run)
);
